// ===== sv/svxff_pkg.sv =====
// ----------------------------------------------------------------------------
// svxff_pkg
// Shared types and constants for the x-sweep VOF face flux pipeline.
// ----------------------------------------------------------------------------
package svxff_pkg;

  localparam int FRAC_W    = 17;
  localparam int VEL_W     = 24;
  localparam int PARM_W    = 24;
  localparam int FLUX_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int VDT_W     = VEL_W + PARM_W - 1;
  localparam int LEN_W     = VDT_W + 1;
  localparam int CDX_W     = FRAC_W - 1 + PARM_W;
  localparam int EDX_W     = FRAC_W + PARM_W;
  localparam int HPROD_W   = VDT_W + FRAC_W - 1;
  localparam int LO_W      = FLUX_W + PARM_W;
  localparam int HI_W      = LEN_W - FLUX_W + PARM_W;

  localparam logic signed [FRAC_W+1:0] FRAC_ONE = (FRAC_W + 2)'(65536);
  localparam logic [FRAC_W-1:0] TOL_RESET = FRAC_W'(66);
  localparam logic [PARM_W-1:0] UNIT_Q8_16 = PARM_W'(65536);

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_HORIZ = 2'd1,
    KIND_VERT  = 2'd2,
    KIND_SAND  = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOL = 2'd0,
    CFG_DT  = 2'd1,
    CFG_DX  = 2'd2,
    CFG_DY  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [FRAC_W-1:0]       frac_left;
    logic [FRAC_W-1:0]       frac_centre;
    logic [FRAC_W-1:0]       frac_right;
    logic signed [VEL_W-1:0] vel_right_face;
    logic signed [VEL_W-1:0] vel_left_face;
  } flux_in_t;

  typedef struct packed {
    logic [FLUX_W-1:0] flux_out_right;
    logic              right_written;
    logic [FLUX_W-1:0] flux_out_left;
    logic              left_written;
    kind_t             interface_kind;
  } flux_out_t;

  typedef struct packed {
    logic [FRAC_W-1:0] tol;
    logic [PARM_W-1:0] dt;
    logic [PARM_W-1:0] dx;
    logic [PARM_W-1:0] dy;
  } cfg_t;

  typedef struct packed {
    kind_t              kind;
    logic               fluid_left;
    logic               centred;
    logic               go_r;
    logic               go_l;
    logic [VDT_W-1:0]   vdt_r;
    logic [VDT_W-1:0]   vdt_l;
    logic [CDX_W-1:0]   cdx;
    logic [EDX_W-1:0]   edx;
    logic [FRAC_W-2:0]  c;
  } s1_t;

  typedef struct packed {
    kind_t            kind;
    logic             fluid_left;
    logic             centred;
    logic             go_r;
    logic             go_l;
    logic [LEN_W-1:0] dist_r;
    logic [LEN_W-1:0] dist_l;
    logic [LEN_W-1:0] horiz_r;
    logic [LEN_W-1:0] horiz_l;
    logic [LEN_W-1:0] full;
    logic [LEN_W-1:0] empty;
    logic [LEN_W-1:0] half_f;
    logic [LEN_W-1:0] half_e;
    logic [LEN_W-1:0] edge_c;
    logic [LEN_W-1:0] edge_s;
  } s2_t;

  typedef struct packed {
    kind_t            kind;
    logic             wr_r;
    logic             wr_l;
    logic [LEN_W-1:0] len_r;
    logic [LEN_W-1:0] len_l;
  } s3_t;

  typedef struct packed {
    kind_t           kind;
    logic            wr_r;
    logic            wr_l;
    logic [LO_W-1:0] lo_r;
    logic [HI_W-1:0] hi_r;
    logic [LO_W-1:0] lo_l;
    logic [HI_W-1:0] hi_l;
  } s4_t;

endpackage

// ===== sv/svxff_classify.sv =====
// ----------------------------------------------------------------------------
// svxff_classify
// Stage 1: interface classification, advection distances and cell lengths.
// ----------------------------------------------------------------------------
module svxff_classify
  import svxff_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     take,
  input  flux_in_t item,
  input  cfg_t     cfg,
  output logic     s1_valid,
  output s1_t      s1
);

  function automatic logic room_above(logic [FRAC_W-1:0] n, logic [FRAC_W-1:0] tol);
    logic signed [FRAC_W+1:0] room;
    room = FRAC_ONE - $signed({2'b00, n});
    return room > $signed({2'b00, tol});
  endfunction

  logic gl, gr, gc, rl, rr, rc;
  logic mid_l, mid_r, low_l, low_r;
  logic go_r, go_l;
  logic [VEL_W-1:0] speed_r, speed_l;
  logic [2*VEL_W-1:0] prod_r, prod_l;
  logic signed [FRAC_W+1:0] room_c;
  logic [FRAC_W-1:0] empty_frac;
  logic [CDX_W-1:0] cdx;
  logic [EDX_W-1:0] edx;
  kind_t kind;
  s1_t s1_next;

  always_comb begin
    gl = item.frac_left > cfg.tol;
    gr = item.frac_right > cfg.tol;
    gc = item.frac_centre > cfg.tol;
    rl = room_above(item.frac_left, cfg.tol);
    rr = room_above(item.frac_right, cfg.tol);
    rc = room_above(item.frac_centre, cfg.tol);
    mid_l = gl && rl;
    mid_r = gr && rr;
    low_l = !gl && !rl;
    low_r = !gr && !rr;

    if (!(gc && rc)) begin
      kind = KIND_NONE;
    end else if ((mid_r || low_r) && (mid_l || low_l)) begin
      kind = KIND_HORIZ;
    end else if ((gl ^ gr) || (rl ^ rr)) begin
      kind = KIND_VERT;
    end else if ((!gr && !gl && rr && rl) || (gr && gl && !rr && !rl)) begin
      kind = KIND_SAND;
    end else begin
      kind = KIND_NONE;
    end

    go_r = !item.vel_right_face[VEL_W-1] && (item.vel_right_face != '0);
    go_l = item.vel_left_face[VEL_W-1];
    speed_r = go_r ? $unsigned(item.vel_right_face) : '0;
    speed_l = go_l ? (VEL_W'(0) - $unsigned(item.vel_left_face)) : '0;
    prod_r = speed_r * cfg.dt;
    prod_l = speed_l * cfg.dt;

    room_c = FRAC_ONE - $signed({2'b00, item.frac_centre});
    empty_frac = room_c[FRAC_W-1:0];
    cdx = item.frac_centre[FRAC_W-2:0] * cfg.dx;
    edx = empty_frac * cfg.dx;

    s1_next.kind       = kind;
    s1_next.fluid_left = item.frac_left > item.frac_right;
    s1_next.centred    = (item.frac_right != '0) && (item.frac_left != '0);
    s1_next.go_r       = go_r;
    s1_next.go_l       = go_l;
    s1_next.vdt_r      = prod_r[VDT_W-1:0];
    s1_next.vdt_l      = prod_l[VDT_W-1:0];
    s1_next.cdx        = cdx;
    s1_next.edx        = edx;
    s1_next.c          = item.frac_centre[FRAC_W-2:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take;
    end
    s1 <= s1_next;
  end

endmodule

// ===== sv/svxff_length.sv =====
// ----------------------------------------------------------------------------
// svxff_length
// Stages 2 and 3: horizontal lengths and edges, then per-face length select.
// ----------------------------------------------------------------------------
module svxff_length
  import svxff_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s1_valid,
  input  s1_t  s1,
  output logic s3_valid,
  output s3_t  s3
);

  function automatic logic [LEN_W-1:0] pick_len(
    kind_t            kind,
    logic             away,
    logic             centred,
    logic [LEN_W-1:0] travel,
    logic [LEN_W-1:0] horiz,
    logic [LEN_W-1:0] full,
    logic [LEN_W-1:0] empty,
    logic [LEN_W-1:0] half_f,
    logic [LEN_W-1:0] half_e,
    logic [LEN_W-1:0] edge_c,
    logic [LEN_W-1:0] edge_s
  );
    logic [LEN_W-1:0] len;
    len = '0;
    case (kind)
      KIND_HORIZ: begin
        len = horiz;
      end
      KIND_VERT: begin
        if (away) begin
          len = (travel > empty) ? travel - empty : '0;
        end else begin
          len = (travel < full) ? travel : full;
        end
      end
      KIND_SAND: begin
        if (centred) begin
          len = (travel < half_f) ? travel : (travel < edge_c) ? half_f : travel - empty;
        end else begin
          len = (travel < half_e) ? '0 : (travel < edge_s) ? travel - half_e : full;
        end
      end
      default: begin
        len = '0;
      end
    endcase
    return len;
  endfunction

  logic [HPROD_W-1:0] hprod_r, hprod_l;
  logic s2_valid;
  s2_t s2, s2_next;
  s3_t s3_next;
  logic [LEN_W-1:0] pick_r, pick_l;

  always_comb begin
    hprod_r = s1.vdt_r * s1.c;
    hprod_l = s1.vdt_l * s1.c;
    s2_next.kind       = s1.kind;
    s2_next.fluid_left = s1.fluid_left;
    s2_next.centred    = s1.centred;
    s2_next.go_r       = s1.go_r;
    s2_next.go_l       = s1.go_l;
    s2_next.dist_r     = {s1.vdt_r, 1'b0};
    s2_next.dist_l     = {s1.vdt_l, 1'b0};
    s2_next.horiz_r    = hprod_r[HPROD_W-1 -: LEN_W];
    s2_next.horiz_l    = hprod_l[HPROD_W-1 -: LEN_W];
    s2_next.full       = LEN_W'({s1.cdx, 1'b0});
    s2_next.empty      = LEN_W'({s1.edx, 1'b0});
    s2_next.half_f     = LEN_W'(s1.cdx);
    s2_next.half_e     = LEN_W'(s1.edx);
    s2_next.edge_c     = LEN_W'(s1.cdx) + LEN_W'({s1.edx, 1'b0});
    s2_next.edge_s     = LEN_W'(s1.edx) + LEN_W'({s1.cdx, 1'b0});
  end

  always_comb begin
    pick_r = pick_len(s2.kind, s2.fluid_left, s2.centred, s2.dist_r, s2.horiz_r,
                      s2.full, s2.empty, s2.half_f, s2.half_e, s2.edge_c, s2.edge_s);
    pick_l = pick_len(s2.kind, !s2.fluid_left, s2.centred, s2.dist_l, s2.horiz_l,
                      s2.full, s2.empty, s2.half_f, s2.half_e, s2.edge_c, s2.edge_s);
    s3_next.kind  = s2.kind;
    s3_next.wr_r  = s2.go_r && (s2.kind != KIND_NONE);
    s3_next.wr_l  = s2.go_l && (s2.kind != KIND_NONE);
    s3_next.len_r = s3_next.wr_r ? pick_r : '0;
    s3_next.len_l = s3_next.wr_l ? pick_l : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
    s2 <= s2_next;
    s3 <= s3_next;
  end

endmodule

// ===== sv/svxff_scale.sv =====
// ----------------------------------------------------------------------------
// svxff_scale
// Stage 4: length times cell height in two partial products; then floor to
// Q16.16 and saturate.
// ----------------------------------------------------------------------------
module svxff_scale
  import svxff_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s3_valid,
  input  s3_t               s3,
  input  logic [PARM_W-1:0] dy,
  output logic              res_valid,
  output flux_out_t         res
);

  function automatic logic [FLUX_W-1:0] to_flux(logic [LO_W-1:0] lo, logic [HI_W-1:0] hi);
    logic [HI_W:0] sum;
    sum = {1'b0, hi} + (HI_W + 1)'(lo[LO_W-1:FLUX_W]);
    return (|sum[HI_W:FLUX_W+1]) ? '1 : sum[FLUX_W:1];
  endfunction

  s4_t s4, s4_next;
  logic s4_valid;

  always_comb begin
    s4_next.kind = s3.kind;
    s4_next.wr_r = s3.wr_r;
    s4_next.wr_l = s3.wr_l;
    s4_next.lo_r = s3.len_r[FLUX_W-1:0] * dy;
    s4_next.hi_r = s3.len_r[LEN_W-1:FLUX_W] * dy;
    s4_next.lo_l = s3.len_l[FLUX_W-1:0] * dy;
    s4_next.hi_l = s3.len_l[LEN_W-1:FLUX_W] * dy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    s4 <= s4_next;
  end

  always_comb begin
    res_valid          = s4_valid;
    res.flux_out_right = to_flux(s4.lo_r, s4.hi_r);
    res.right_written  = s4.wr_r;
    res.flux_out_left  = to_flux(s4.lo_l, s4.hi_l);
    res.left_written   = s4.wr_l;
    res.interface_kind = s4.kind;
  end

endmodule

// ===== sv/svxff_queue.sv =====
// ----------------------------------------------------------------------------
// svxff_queue
// Result queue with credit count: intake stalls once the queue could fill.
// ----------------------------------------------------------------------------
module svxff_queue
  import svxff_pkg::*;
#(
  parameter int DEPTH = 8
)
(
  input  logic      clk,
  input  logic      rst,
  input  logic      take,
  input  logic      push,
  input  flux_out_t push_data,
  output logic      out_valid,
  input  logic      out_stall,
  output flux_out_t out_data,
  output logic      busy
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  flux_out_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, credits;
  logic pop;

  assign out_valid = count != '0;
  assign pop       = out_valid && !out_stall;
  assign out_data  = mem[rd_ptr];
  assign busy      = credits == CNT_W'(DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      count   <= '0;
      credits <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      count   <= count + CNT_W'(push) - CNT_W'(pop);
      credits <= credits + CNT_W'(take) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== sv/slic_vof_x_face_flux.sv =====
// ----------------------------------------------------------------------------
// slic_vof_x_face_flux
// SLIC VOF donated flux, x sweep: one grid cell per transaction.
// ----------------------------------------------------------------------------
// Each result passes the pipeline stages and the result queue before output.
// Throughput: one transaction per cycle while in_stall is low; four pipeline
// stages then a result queue of QUEUE_DEPTH entries (at least 6 for full rate
// under no stall).
// in_stall rises when QUEUE_DEPTH transactions are in flight or queued.
// Reset (rst, synchronous): empties the pipe and queue, restores registers.
module slic_vof_x_face_flux
  import svxff_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8
)
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  flux_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output flux_out_t            out_data,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PARM_W-1:0]    cfg_data
);

  cfg_t cfg;
  logic take;
  logic s1_valid, s3_valid, res_valid;
  s1_t s1;
  s3_t s3;
  flux_out_t res;

  assign take = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tol <= TOL_RESET;
      cfg.dt  <= UNIT_Q8_16;
      cfg.dx  <= UNIT_Q8_16;
      cfg.dy  <= UNIT_Q8_16;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_TOL: cfg.tol <= cfg_data[FRAC_W-1:0];
        CFG_DT:  cfg.dt  <= cfg_data;
        CFG_DX:  cfg.dx  <= cfg_data;
        CFG_DY:  cfg.dy  <= cfg_data;
      endcase
    end
  end

  svxff_classify u_classify (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .item     (in_data),
    .cfg      (cfg),
    .s1_valid (s1_valid),
    .s1       (s1)
  );

  svxff_length u_length (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1       (s1),
    .s3_valid (s3_valid),
    .s3       (s3)
  );

  svxff_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .s3_valid  (s3_valid),
    .s3        (s3),
    .dy        (cfg.dy),
    .res_valid (res_valid),
    .res       (res)
  );

  svxff_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .push      (res_valid),
    .push_data (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .busy      (in_stall)
  );

endmodule

// ===== sv/svxff_checker.sv =====
// ----------------------------------------------------------------------------
// svxff_checker
// Port-level checks for the x-sweep face flux block, bound to the top level.
// ----------------------------------------------------------------------------
module svxff_checker
  import svxff_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input flux_out_t out_data
);

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !in_stall && !out_valid ##1 !out_valid ##1 !out_valid ##1 !out_valid)
    else $error("result or stall too soon after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_unwritten_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (!out_data.right_written || !out_data.left_written) |->
      (out_data.right_written || out_data.flux_out_right == '0) &&
      (out_data.left_written || out_data.flux_out_left == '0))
    else $error("unwritten flux not zero");

  a_none_silent: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.interface_kind == KIND_NONE |->
      !out_data.right_written && !out_data.left_written)
    else $error("flux written without interface");

endmodule

bind slic_vof_x_face_flux svxff_checker u_checker (.*);
